FILE: sv/truecolor_pixel_to_rgb888_unit_defines.svh
// Assertion macros shared by the pixel converter modules.
// TRC_ASSERT expects clk and arst_n in scope; the other only clk.
`ifndef TRUECOLOR_PIXEL_TO_RGB888_UNIT_DEFINES_SVH
`define TRUECOLOR_PIXEL_TO_RGB888_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property once reset is released.
`define TRC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define TRC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TRC_ASSERT(label, prop, msg)
`define TRC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: sv/trc_pkg.sv
package trc_pkg;

	localparam int unsigned NUM_CH              = 3;
	localparam int unsigned DIV_STEPS_PER_STAGE = 2;

	// Register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_PIXEL_MODE = 3'd0,
		REG_BYTE_ORDER = 3'd1,
		REG_RED_MASK   = 3'd2,
		REG_GREEN_MASK = 3'd3,
		REG_BLUE_MASK  = 3'd4
	} cfg_reg_t;

	// Pixel modes (the unused code behaves as 16 bpp)
	typedef enum logic [1:0] {
		MODE_16 = 2'd0,
		MODE_24 = 2'd1,
		MODE_32 = 2'd2
	} pix_mode_t;

	localparam logic [1:0]        PIXEL_MODE_RST = MODE_32;
	localparam logic              BYTE_ORDER_RST = 1'b0;
	// Channel 0 red, 1 green, 2 blue
	localparam logic [2:0][31:0]  MASK_RST = {32'h0000_00FF, 32'h0000_FF00, 32'h00FF_0000};

	typedef struct packed {
		logic [7:0] byte_zero;
		logic [7:0] byte_one;
		logic [7:0] byte_two;
		logic [7:0] byte_three;
		logic       row_end_in;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       row_end_out;
	} pix_out_t;

	// Decoded configuration, per channel shift, maximum and zero-mask flag
	typedef struct packed {
		logic [1:0]             mode;
		logic                   msb_first;
		logic [2:0][4:0]        shift;
		logic [2:0][15:0]       chan_max;
		logic [2:0]             zero;
		logic                   fast;
	} cfg_t;

	// First stage: masked channel values or final bytes for the direct paths
	typedef struct packed {
		logic [2:0][15:0] chan;
		logic [2:0][7:0]  dbyte;
		logic [2:0]       zero;
		logic             direct;
		logic             row_end;
	} s1_t;

	// Divider stages: partial remainder and quotient per channel
	typedef struct packed {
		logic [2:0][23:0] rem;
		logic [2:0][7:0]  quo;
		logic [2:0][7:0]  dbyte;
		logic [2:0]       zero;
		logic             direct;
		logic             row_end;
	} div_t;

	function automatic logic [4:0] low_bit_index(logic [31:0] m);
		logic [4:0] idx;
		idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (m[i]) idx = 5'(i);
		end
		return idx;
	endfunction

	function automatic logic [15:0] chan_max(logic [31:0] m);
		logic [31:0] s;
		s = m >> low_bit_index(m);
		return s[15:0];
	endfunction

	// Two restoring division steps per channel; divisor aligned at bit 7
	function automatic div_t div_pair(div_t d, logic [2:0][15:0] mx);
		div_t        r;
		logic [23:0] dv;
		r = d;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			dv = 24'(mx[ch]) << 7;
			for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
				if (r.rem[ch] >= dv) begin
					r.rem[ch] = r.rem[ch] - dv;
					r.quo[ch] = {r.quo[ch][6:0], 1'b1};
				end else begin
					r.quo[ch] = {r.quo[ch][6:0], 1'b0};
				end
				r.rem[ch] = r.rem[ch] << 1;
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/trc_cfg.sv
`include "truecolor_pixel_to_rgb888_unit_defines.svh"

module trc_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	output trc_pkg::cfg_t      cfg
);

	logic [1:0]       mode_q;
	logic             msb_q;
	logic [2:0][4:0]  shift_q;
	logic [2:0][15:0] max_q;
	logic [2:0]       zero_q;

	logic [4:0]  wr_shift;
	logic [31:0] wr_shifted;
	logic        wr_zero;

	// Decode a mask on its way in
	always_comb begin
		wr_shift   = trc_pkg::low_bit_index(cfg_wdata);
		wr_shifted = cfg_wdata >> wr_shift;
		wr_zero    = (cfg_wdata == 32'h0);
	end

	// Hold the registers, update on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= trc_pkg::PIXEL_MODE_RST;
			msb_q  <= trc_pkg::BYTE_ORDER_RST;
			for (int ch = 0; ch < trc_pkg::NUM_CH; ch++) begin
				shift_q[ch] <= trc_pkg::low_bit_index(trc_pkg::MASK_RST[ch]);
				max_q[ch]   <= trc_pkg::chan_max(trc_pkg::MASK_RST[ch]);
				zero_q[ch]  <= (trc_pkg::MASK_RST[ch] == 32'h0);
			end
		end else if (cfg_wen) begin
			case (cfg_index)
				trc_pkg::REG_PIXEL_MODE: mode_q <= cfg_wdata[1:0];
				trc_pkg::REG_BYTE_ORDER: msb_q  <= cfg_wdata[0];
				trc_pkg::REG_RED_MASK: begin
					shift_q[0] <= wr_shift;
					max_q[0]   <= wr_shifted[15:0];
					zero_q[0]  <= wr_zero;
				end
				trc_pkg::REG_GREEN_MASK: begin
					shift_q[1] <= wr_shift;
					max_q[1]   <= wr_shifted[15:0];
					zero_q[1]  <= wr_zero;
				end
				trc_pkg::REG_BLUE_MASK: begin
					shift_q[2] <= wr_shift;
					max_q[2]   <= wr_shifted[15:0];
					zero_q[2]  <= wr_zero;
				end
				default: ;
			endcase
		end
	end

	// Fast path: every channel present and eight bits wide
	always_comb begin
		cfg.mode      = mode_q;
		cfg.msb_first = msb_q;
		cfg.shift     = shift_q;
		cfg.chan_max  = max_q;
		cfg.zero      = zero_q;
		cfg.fast      = (zero_q == 3'b000) && (max_q[0] == 16'h00FF) &&
			(max_q[1] == 16'h00FF) && (max_q[2] == 16'h00FF);
	end

	`TRC_ASSERT(a_red_zero_max, zero_q[0] == (max_q[0] == 16'h0), "red zero flag and maximum disagree")
	`TRC_ASSERT(a_blue_zero_max, zero_q[2] == (max_q[2] == 16'h0), "blue zero flag and maximum disagree")

endmodule

FILE: sv/trc_front.sv
`include "truecolor_pixel_to_rgb888_unit_defines.svh"

module trc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  trc_pkg::cfg_t     cfg,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  trc_pkg::pix_in_t  pixel,
	output logic              fwd_valid,
	input  logic              fwd_ready,
	output trc_pkg::div_t     fwd
);

	logic              vld_s1;
	trc_pkg::s1_t      data_s1;
	logic              vld_s2;
	trc_pkg::div_t     data_s2;

	logic              rdy_s1;
	logic              rdy_s2;
	logic [31:0]       word;
	logic [2:0][31:0]  sh;
	logic [2:0][7:0]   bytes;
	logic              mode24;
	logic              mode32;
	trc_pkg::s1_t      nxt_s1;
	trc_pkg::div_t     nxt_s2;

	assign rdy_s2      = !vld_s2 || fwd_ready;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign pixel_ready = rdy_s1;

	// Assemble the pixel word and pull each channel down to bit 0
	always_comb begin
		mode24 = (cfg.mode == trc_pkg::MODE_24);
		mode32 = (cfg.mode == trc_pkg::MODE_32);
		bytes  = {pixel.byte_two, pixel.byte_one, pixel.byte_zero};
		if (mode32) begin
			if (cfg.fast) begin
				word = cfg.msb_first ?
					{8'h00, pixel.byte_one, pixel.byte_two, pixel.byte_three} :
					{8'h00, pixel.byte_two, pixel.byte_one, pixel.byte_zero};
			end else begin
				word = cfg.msb_first ?
					{pixel.byte_zero, pixel.byte_one, pixel.byte_two, pixel.byte_three} :
					{pixel.byte_three, pixel.byte_two, pixel.byte_one, pixel.byte_zero};
			end
		end else begin
			word = cfg.msb_first ?
				{16'h0000, pixel.byte_zero, pixel.byte_one} :
				{16'h0000, pixel.byte_one, pixel.byte_zero};
		end
		for (int ch = 0; ch < trc_pkg::NUM_CH; ch++) begin
			sh[ch]            = word >> cfg.shift[ch];
			nxt_s1.chan[ch]   = sh[ch][15:0] & cfg.chan_max[ch];
			nxt_s1.dbyte[ch]  = mode24 ? bytes[ch] : sh[ch][7:0];
		end
		nxt_s1.zero    = cfg.zero;
		nxt_s1.direct  = mode24 || (mode32 && cfg.fast);
		nxt_s1.row_end = pixel.row_end_in;
	end

	// Form the rounded numerator c*255 + max/2
	always_comb begin
		for (int ch = 0; ch < trc_pkg::NUM_CH; ch++) begin
			nxt_s2.rem[ch] = (24'(data_s1.chan[ch]) << 8) - 24'(data_s1.chan[ch]) +
				24'(cfg.chan_max[ch] >> 1);
			nxt_s2.quo[ch] = 8'h00;
		end
		nxt_s2.dbyte   = data_s1.dbyte;
		nxt_s2.zero    = data_s1.zero;
		nxt_s2.direct  = data_s1.direct;
		nxt_s2.row_end = data_s1.row_end;
	end

	// Advance valid bits when the next stage has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= pixel_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	// Load payload only with a request behind it
	always_ff @(posedge clk) begin
		if (rdy_s1 && pixel_valid) data_s1 <= nxt_s1;
		if (rdy_s2 && vld_s1) data_s2 <= nxt_s2;
	end

	assign fwd_valid = vld_s2;
	assign fwd       = data_s2;

	`TRC_ASSERT(a_chan_in_range, vld_s1 |-> (data_s1.chan[1] <= cfg.chan_max[1]), "green channel above its maximum")
	`TRC_ASSERT(a_num_in_range, vld_s2 && !data_s2.zero[0] |-> (data_s2.rem[0] < (24'(cfg.chan_max[0]) << 8)), "red numerator gives a quotient above 255")

endmodule

FILE: sv/trc_div.sv
`include "truecolor_pixel_to_rgb888_unit_defines.svh"

module trc_div (
	input  logic           clk,
	input  logic           arst_n,
	input  trc_pkg::cfg_t  cfg,
	input  logic           fwd_valid,
	output logic           fwd_ready,
	input  trc_pkg::div_t  fwd,
	output logic           res_valid,
	input  logic           res_ready,
	output trc_pkg::div_t  res
);

	logic           vld_s3;
	logic           vld_s4;
	logic           vld_s5;
	logic           vld_s6;
	trc_pkg::div_t  data_s3;
	trc_pkg::div_t  data_s4;
	trc_pkg::div_t  data_s5;
	trc_pkg::div_t  data_s6;

	logic           rdy_s3;
	logic           rdy_s4;
	logic           rdy_s5;
	logic           rdy_s6;

	assign rdy_s6    = !vld_s6 || res_ready;
	assign rdy_s5    = !vld_s5 || rdy_s6;
	assign rdy_s4    = !vld_s4 || rdy_s5;
	assign rdy_s3    = !vld_s3 || rdy_s4;
	assign fwd_ready = rdy_s3;

	// Advance valid bits through the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (rdy_s3) vld_s3 <= fwd_valid;
			if (rdy_s4) vld_s4 <= vld_s3;
			if (rdy_s5) vld_s5 <= vld_s4;
			if (rdy_s6) vld_s6 <= vld_s5;
		end
	end

	// Retire two quotient bits per stage, most significant first
	always_ff @(posedge clk) begin
		if (rdy_s3 && fwd_valid) data_s3 <= trc_pkg::div_pair(fwd, cfg.chan_max);
		if (rdy_s4 && vld_s3) data_s4 <= trc_pkg::div_pair(data_s3, cfg.chan_max);
		if (rdy_s5 && vld_s4) data_s5 <= trc_pkg::div_pair(data_s4, cfg.chan_max);
		if (rdy_s6 && vld_s5) data_s6 <= trc_pkg::div_pair(data_s5, cfg.chan_max);
	end

	assign res_valid = vld_s6;
	assign res       = data_s6;

	`TRC_ASSERT(a_rem_bounded, vld_s6 && !data_s6.zero[2] |-> (data_s6.rem[2] < (24'(cfg.chan_max[2]) << 8)), "blue remainder out of range after last step")

endmodule

FILE: sv/truecolor_pixel_to_rgb888_unit.sv
// Framebuffer pixel to RGB888 converter.
// Pixel channel (pixel_valid / pixel_ready / pixel) takes up to four raw bytes
// in memory order and a row-end mark; the rgb channel (rgb_valid / rgb_ready /
// rgb) returns 8-bit red, green and blue with the mark copied through.
// The configuration port writes one register per cycle with cfg_wen high:
// index 0 pixel mode, 1 byte order, 2..4 red, green and blue masks. Mask
// shift and maximum are decoded as the mask is written. Write only while no
// request is in flight.
// Six register stages: word assembly and channel shift, the rounded numerator
// c*255 + max/2, then four divider stages that retire two quotient bits each.
// rgb_valid rises once the pixel has passed through all of these stages in order.
// One pixel is accepted every cycle while the pipeline is not stalled.
// Reset clears all pipeline valid bits and loads 32 bpp, least significant
// byte first, masks 0xFF0000, 0x00FF00 and 0x0000FF.
// When rgb_ready is low the last stage holds its result and stages behind it
// keep filling until the pipeline is full; pixel_ready then drops. Nothing
// is lost or repeated.
`include "truecolor_pixel_to_rgb888_unit_defines.svh"

module truecolor_pixel_to_rgb888_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_wdata,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  trc_pkg::pix_in_t   pixel,
	output logic               rgb_valid,
	input  logic               rgb_ready,
	output trc_pkg::pix_out_t  rgb
);

	trc_pkg::cfg_t  cfg;
	logic           fwd_valid;
	logic           fwd_ready;
	trc_pkg::div_t  fwd;
	trc_pkg::div_t  res;
	logic [2:0][7:0] chan_out;

	trc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	trc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.fwd_valid   (fwd_valid),
		.fwd_ready   (fwd_ready),
		.fwd         (fwd)
	);

	trc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fwd_valid (fwd_valid),
		.fwd_ready (fwd_ready),
		.fwd       (fwd),
		.res_valid (rgb_valid),
		.res_ready (rgb_ready),
		.res       (res)
	);

	// Pick the direct byte, zero for an empty mask, or the quotient
	always_comb begin
		for (int ch = 0; ch < trc_pkg::NUM_CH; ch++) begin
			if (res.direct) begin
				chan_out[ch] = res.dbyte[ch];
			end else if (res.zero[ch]) begin
				chan_out[ch] = 8'h00;
			end else begin
				chan_out[ch] = res.quo[ch];
			end
		end
		rgb.red_out     = chan_out[0];
		rgb.green_out   = chan_out[1];
		rgb.blue_out    = chan_out[2];
		rgb.row_end_out = res.row_end;
	end

	`TRC_ASSERT(a_empty_accepts, !rgb_valid |-> pixel_ready, "pipeline refuses a request while its output stage is empty")

endmodule

FILE: dv/truecolor_pixel_to_rgb888_unit_tb.sv
`timescale 1ns / 100ps

module truecolor_pixel_to_rgb888_unit_tb;
	import trc_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned PIPE_LATENCY  = 6;
	localparam int unsigned REG_COUNT     = 5;
	localparam int unsigned RANDOM_PHASES = 17;
	localparam logic [1:0]  MODE_UNUSED   = 2'd3;
	localparam logic        LSB_FIRST     = 1'b0;
	localparam logic        MSB_FIRST     = 1'b1;
	localparam logic [31:0] CHAN_FULL     = 32'd255;

	typedef enum int unsigned {
		READY_ALWAYS,
		READY_COIN,
		READY_PATTERN,
		READY_BLOCKS
	} ready_style_t;

	typedef enum int unsigned {
		LAYOUT_SPAN,
		LAYOUT_BYTES,
		LAYOUT_NOISE
	} mask_layout_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        pixel_valid;
	logic        pixel_ready;
	pix_in_t     pixel;
	logic        rgb_valid;
	logic        rgb_ready;
	pix_out_t    rgb;

	// Shadow of the configuration registers
	logic [1:0]  shadow_mode;
	logic        shadow_msb;
	logic [31:0] shadow_red;
	logic [31:0] shadow_green;
	logic [31:0] shadow_blue;

	pix_out_t     expected_rgb [$];
	pix_out_t     want_rgb;
	int unsigned  fail_count;
	int unsigned  cycle_count;
	int unsigned  burst_left;
	bit           sender_gaps;
	ready_style_t ready_style;
	logic [15:0]  ready_pattern;
	logic [3:0]   pattern_pos;
	int unsigned  stall_left;

	truecolor_pixel_to_rgb888_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.rgb_valid   (rgb_valid),
		.rgb_ready   (rgb_ready),
		.rgb         (rgb)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Position of the lowest set bit, zero for an empty mask
	function automatic logic [4:0] mask_shift(logic [31:0] m);
		logic [4:0] pos;
		logic       hit;
		pos = '0;
		hit = 1'b0;
		for (int i = 0; i < 32; i++) begin
			if (m[i] && !hit) begin
				pos = 5'(i);
				hit = 1'b1;
			end
		end
		return pos;
	endfunction

	function automatic logic [15:0] mask_peak(logic [31:0] m);
		logic [31:0] s;
		s = m >> mask_shift(m);
		return s[15:0];
	endfunction

	// Extract one channel and scale it to eight bits with rounding
	function automatic logic [7:0] scale_channel(logic [31:0] word, logic [31:0] m);
		logic [31:0] peak;
		logic [31:0] c;
		logic [31:0] num;
		logic [7:0]  res;
		res = '0;
		if (m != '0) begin
			peak = 32'(mask_peak(m));
			c    = (word >> mask_shift(m)) & peak;
			num  = c * CHAN_FULL + peak / 32'd2;
			res  = 8'(num / peak);
		end
		return res;
	endfunction

	function automatic pix_out_t predict_rgb(pix_in_t p);
		pix_out_t    r;
		logic [31:0] word;
		logic        fast;
		r.row_end_out = p.row_end_in;
		case (shadow_mode)
			MODE_24: begin
				r.red_out   = p.byte_zero;
				r.green_out = p.byte_one;
				r.blue_out  = p.byte_two;
			end
			MODE_32: begin
				fast = shadow_red != '0 && shadow_green != '0 && shadow_blue != '0 &&
					32'(mask_peak(shadow_red)) == CHAN_FULL &&
					32'(mask_peak(shadow_green)) == CHAN_FULL &&
					32'(mask_peak(shadow_blue)) == CHAN_FULL;
				if (fast) begin
					// Three bytes only, shift and truncate
					if (shadow_msb)
						word = {8'h00, p.byte_one, p.byte_two, p.byte_three};
					else
						word = {8'h00, p.byte_two, p.byte_one, p.byte_zero};
					r.red_out   = 8'(word >> mask_shift(shadow_red));
					r.green_out = 8'(word >> mask_shift(shadow_green));
					r.blue_out  = 8'(word >> mask_shift(shadow_blue));
				end else begin
					if (shadow_msb)
						word = {p.byte_zero, p.byte_one, p.byte_two, p.byte_three};
					else
						word = {p.byte_three, p.byte_two, p.byte_one, p.byte_zero};
					r.red_out   = scale_channel(word, shadow_red);
					r.green_out = scale_channel(word, shadow_green);
					r.blue_out  = scale_channel(word, shadow_blue);
				end
			end
			default: begin
				// 16 bpp, also taken by the unused mode code
				if (shadow_msb)
					word = {16'h0000, p.byte_zero, p.byte_one};
				else
					word = {16'h0000, p.byte_one, p.byte_zero};
				r.red_out   = scale_channel(word, shadow_red);
				r.green_out = scale_channel(word, shadow_green);
				r.blue_out  = scale_channel(word, shadow_blue);
			end
		endcase
		return r;
	endfunction

	function automatic pix_in_t make_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3, logic row_end);
		pix_in_t p;
		p.byte_zero  = b0;
		p.byte_one   = b1;
		p.byte_two   = b2;
		p.byte_three = b3;
		p.row_end_in = row_end;
		return p;
	endfunction

	// Random byte, biased toward the extremes
	function automatic logic [7:0] random_byte();
		logic [7:0] b;
		case ($urandom_range(0, 15))
			0:       b = 8'h00;
			1:       b = 8'hFF;
			default: b = 8'($urandom());
		endcase
		return b;
	endfunction

	function automatic logic [31:0] span_mask(int unsigned width, int unsigned pos);
		logic [63:0] m;
		m = ((64'd1 << width) - 64'd1) << pos;
		return m[31:0];
	endfunction

	function automatic logic [31:0] pick_mask(mask_layout_t layout, int unsigned word_bits);
		logic [31:0] m;
		int unsigned w;
		case (layout)
			LAYOUT_BYTES: m = span_mask(8, $urandom_range(0, 24));
			LAYOUT_NOISE: m = $urandom();
			default: begin
				w = $urandom_range(1, word_bits);
				m = span_mask(w, $urandom_range(0, word_bits - w));
				if ($urandom_range(0, 9) == 0)
					m = '0;
			end
		endcase
		return m;
	endfunction

	// Check each result against the oldest pending request
	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rgb_valid && rgb_ready) begin
			if (expected_rgb.size() == 0) begin
				$error("rgb result with no request pending");
				fail_count++;
			end else begin
				want_rgb = expected_rgb.pop_front();
				check_field("red_out", want_rgb.red_out, rgb.red_out);
				check_field("green_out", want_rgb.green_out, rgb.green_out);
				check_field("blue_out", want_rgb.blue_out, rgb.blue_out);
				check_field("row_end_out", 8'(want_rgb.row_end_out), 8'(rgb.row_end_out));
			end
		end
	end

	// Drive the receiver stalls
	initial begin
		rgb_ready   = 1'b0;
		stall_left  = 0;
		pattern_pos = '0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				rgb_ready <= 1'b0;
				stall_left--;
			end else begin
				case (ready_style)
					READY_COIN: rgb_ready <= 1'($urandom_range(0, 1));
					READY_PATTERN: begin
						rgb_ready   <= ready_pattern[pattern_pos];
						pattern_pos = pattern_pos + 4'd1;
					end
					READY_BLOCKS: begin
						rgb_ready <= 1'b1;
						if ($urandom_range(0, 19) == 0)
							stall_left = $urandom_range(4, 30);
					end
					default: rgb_ready <= 1'b1;
				endcase
			end
		end
	end

	// Bound the run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Insert a random gap, possibly none, at the start of each burst when gaps are on
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				pixel_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_pixel(input pix_in_t p);
		pace_sender();
		@(negedge clk);
		pixel_valid <= 1'b1;
		pixel       <= p;
		do @(posedge clk); while (!pixel_ready);
		expected_rgb.push_back(predict_rgb(p));
	endtask

	// Drop valid and wait until every request has come back
	task automatic drain_pipeline();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (expected_rgb.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_PIXEL_MODE: shadow_mode  = data[1:0];
			REG_BYTE_ORDER: shadow_msb   = data[0];
			REG_RED_MASK:   shadow_red   = data;
			REG_GREEN_MASK: shadow_green = data;
			REG_BLUE_MASK:  shadow_blue  = data;
			default: ;
		endcase
	endtask

	// Reprogram every register once the pipeline is empty
	task automatic apply_config(input logic [1:0] mode, input logic order,
			input logic [31:0] red_m, input logic [31:0] green_m, input logic [31:0] blue_m,
			input bit junk);
		logic [31:0] data;
		drain_pipeline();
		data = $urandom();
		data[1:0] = mode;
		write_reg(REG_PIXEL_MODE, data);
		data = $urandom();
		data[0] = order;
		write_reg(REG_BYTE_ORDER, data);
		write_reg(REG_RED_MASK, red_m);
		write_reg(REG_GREEN_MASK, green_m);
		write_reg(REG_BLUE_MASK, blue_m);
		if (junk)
			write_reg(3'($urandom_range(REG_COUNT, 7)), $urandom());
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
	endtask

	task automatic test_packed_24();
		apply_config(MODE_24, LSB_FIRST, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 1'b0);
		send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0));
		send_pixel(make_pixel(8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b1));
	endtask

	task automatic test_rgb565_orders();
		apply_config(MODE_16, LSB_FIRST, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 1'b0);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0));
		send_pixel(make_pixel(8'h1F, 8'hF8, 8'hFF, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'hE0, 8'h07, 8'h55, 8'hAA, 1'b0));
		apply_config(MODE_16, MSB_FIRST, 32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 1'b0);
		send_pixel(make_pixel(8'hF8, 8'h1F, 8'h00, 8'h00, 1'b1));
		send_pixel(make_pixel(8'h07, 8'hE0, 8'hFF, 8'hFF, 1'b0));
	endtask

	task automatic test_wide_and_zero_masks();
		// 10-bit channels take the scaling path in 32 bpp
		apply_config(MODE_32, LSB_FIRST, 32'h3FF0_0000, 32'h000F_FC00, 32'h0000_03FF, 1'b0);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'h3F, 1'b0));
		send_pixel(make_pixel(8'h00, 8'h02, 8'h10, 8'h20, 1'b1));
		// Full mask caps the maximum at 16 bits; empty mask gives zero
		apply_config(MODE_32, MSB_FIRST, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'h80, 8'h00, 8'h12, 8'h34, 1'b0));
	endtask

	task automatic test_fast_path();
		apply_config(MODE_32, MSB_FIRST, 32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 1'b0);
		send_pixel(make_pixel(8'h11, 8'h22, 8'h33, 8'h44, 1'b1));
		// Red above the three-byte word reads as zero
		apply_config(MODE_32, LSB_FIRST, 32'hFF00_0000, 32'h00FF_0000, 32'h0001_FE00, 1'b0);
		send_pixel(make_pixel(8'hAB, 8'hCD, 8'hEF, 8'h01, 1'b0));
	endtask

	task automatic test_shift_out();
		apply_config(MODE_16, LSB_FIRST, 32'h8000_0000, 32'h0001_0000, 32'h0000_FFFF, 1'b0);
		send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
		send_pixel(make_pixel(8'h34, 8'h12, 8'h00, 8'h00, 1'b0));
	endtask

	task automatic test_unused_mode_and_index();
		apply_config(MODE_UNUSED, MSB_FIRST, 32'h0000_F000, 32'h0000_0F00, 32'h0000_00F0, 1'b1);
		send_pixel(make_pixel(8'hF1, 8'h23, 8'h45, 8'h67, 1'b1));
		send_pixel(make_pixel(8'h0F, 8'hED, 8'hCB, 8'hA9, 1'b0));
	endtask

	task automatic test_random_traffic();
		int unsigned  count;
		int unsigned  bits;
		logic [1:0]   mode;
		mask_layout_t layout;
		pix_in_t      p;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: mode = MODE_16;
				4:          mode = MODE_24;
				9:          mode = MODE_UNUSED;
				default:    mode = MODE_32;
			endcase
			case ($urandom_range(0, 9))
				5, 6, 7: layout = LAYOUT_BYTES;
				8, 9:    layout = LAYOUT_NOISE;
				default: layout = LAYOUT_SPAN;
			endcase
			bits = (mode == MODE_32) ? 32 : 16;
			apply_config(mode, 1'($urandom_range(0, 1)), pick_mask(layout, bits),
				pick_mask(layout, bits), pick_mask(layout, bits), $urandom_range(0, 3) == 0);
			// Run the first phase with no idling on either side
			if (phase == 0) begin
				ready_style = READY_ALWAYS;
				sender_gaps = 1'b0;
			end else begin
				ready_style   = ready_style_t'($urandom_range(0, 3));
				ready_pattern = 16'($urandom()) | 16'h0001;
				sender_gaps   = $urandom_range(0, 3) != 0;
			end
			count = $urandom_range(90, 110);
			repeat (count) begin
				p = make_pixel(random_byte(), random_byte(), random_byte(), random_byte(),
					$urandom_range(0, 5) == 0);
				send_pixel(p);
			end
		end
	endtask

	initial begin
		cfg_wen       = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		pixel_valid   = 1'b0;
		pixel         = '0;
		arst_n        = 1'b0;
		fail_count    = 0;
		burst_left    = 0;
		sender_gaps   = 1'b1;
		ready_style   = READY_COIN;
		ready_pattern = 16'hFFFF;
		shadow_mode   = PIXEL_MODE_RST;
		shadow_msb    = BYTE_ORDER_RST;
		shadow_red    = MASK_RST[0];
		shadow_green  = MASK_RST[1];
		shadow_blue   = MASK_RST[2];
		// Hold reset, then release between edges
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_packed_24();
		test_rgb565_orders();
		test_wide_and_zero_masks();
		test_fast_path();
		test_shift_out();
		test_unused_mode_and_index();
		test_random_traffic();
		drain_pipeline();

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
